/* sv/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; every other file of the block uses it.
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CpW-1:0] END_CP         = 21'h000000;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]     expect_cnt;  // continuation bytes still awaited, 0 = idle
    logic [CpW-1:0] partial;     // payload bits gathered so far
    logic [1:0]     taken_cnt;   // continuation bytes already accepted
  } dec_state_t;

  // Everything one byte produces: replacements first, then an optional tail.
  typedef struct packed {
    logic [1:0]     repl_cnt;
    logic           tail_v;
    logic [CpW-1:0] tail_cp;
    logic           tail_end;
  } result_desc_t;

  // Status from the result stage back to the input register.
  typedef struct packed {
    logic empty;
    logic finishing;
  } emit_stat_t;

endpackage

/* sv/utf8d_if.sv */
// Handshake channels of the decoder: bytes in, code points out.
// Depends on utf8d_pkg for the code point width.
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface utf8d_out_if;
  logic                         valid;
  logic                         ready;
  logic [utf8d_pkg::CpW-1:0]    code_point;
  logic                         last_of_run;
  logic                         end_of_text;

  modport source (output valid, output code_point, output last_of_run,
                  output end_of_text, input ready);
  modport sink   (input valid, input code_point, input last_of_run,
                  input end_of_text, output ready);
endinterface

/* sv/utf8d_step.sv */
// Combinational decode of one byte against the current decoder state.
// Depends on utf8d_pkg for the state and result descriptor types.
module utf8d_step (
  input  logic [7:0]              text_byte,
  input  utf8d_pkg::dec_state_t   cur,
  output utf8d_pkg::dec_state_t   nxt,
  output utf8d_pkg::result_desc_t desc
);

  logic                      is_cont;
  logic                      fresh;
  logic [utf8d_pkg::CpW-1:0] shifted;

  assign is_cont = (text_byte[7:6] == 2'b10);
  assign shifted = {cur.partial[utf8d_pkg::CpW-7:0], text_byte[5:0]};

  always_comb begin
    nxt   = cur;
    desc  = '0;
    fresh = 1'b0;

    // An open sequence either takes the byte or breaks.
    if (cur.expect_cnt != 2'd0) begin
      if (is_cont) begin
        nxt.partial    = shifted;
        nxt.taken_cnt  = 2'(cur.taken_cnt + 2'd1);
        nxt.expect_cnt = 2'(cur.expect_cnt - 2'd1);
        if (cur.expect_cnt == 2'd1) begin
          desc.tail_v   = 1'b1;
          desc.tail_cp  = shifted;
          nxt.partial   = '0;
          nxt.taken_cnt = 2'd0;
        end
      end else begin
        // One replacement for the lead, one per continuation taken (two at most).
        desc.repl_cnt = 2'(2'd1 + (cur.taken_cnt[1] ? 2'd2 : cur.taken_cnt));
        nxt   = '0;
        fresh = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    // Decode the byte with no sequence open.
    if (fresh) begin
      if (text_byte == 8'h00) begin
        desc.tail_v   = 1'b1;
        desc.tail_cp  = utf8d_pkg::END_CP;
        desc.tail_end = 1'b1;
      end else if (text_byte[7] == 1'b0) begin
        desc.tail_v  = 1'b1;
        desc.tail_cp = {13'd0, text_byte};
      end else if (text_byte[6] == 1'b0) begin
        desc.tail_v  = 1'b1;
        desc.tail_cp = utf8d_pkg::REPLACEMENT_CP;
      end else if (text_byte[5] == 1'b0) begin
        nxt.partial    = {16'd0, text_byte[4:0]};
        nxt.expect_cnt = 2'd1;
        nxt.taken_cnt  = 2'd0;
      end else if (text_byte[4] == 1'b0) begin
        nxt.partial    = {17'd0, text_byte[3:0]};
        nxt.expect_cnt = 2'd2;
        nxt.taken_cnt  = 2'd0;
      end else begin
        nxt.partial    = {18'd0, text_byte[2:0]};
        nxt.expect_cnt = 2'd3;
        nxt.taken_cnt  = 2'd0;
      end
    end
  end

endmodule

/* sv/utf8d_emit.sv */
// Result register: holds the results of one byte and sends them one per cycle while out_bus is ready.
// Depends on utf8d_pkg and the utf8d_out_if channel.
module utf8d_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  utf8d_pkg::result_desc_t desc,
  output utf8d_pkg::emit_stat_t   stat,
  utf8d_out_if.source             out_bus
);

  logic [1:0]                repl_r, repl_nxt;
  logic                      tail_v_r, tail_v_nxt;
  logic [utf8d_pkg::CpW-1:0] tail_cp_r;
  logic                      tail_end_r;
  logic                      fire;
  logic                      is_last;

  assign fire    = out_bus.valid && out_bus.ready;
  assign is_last = (repl_r == 2'd0) || ((repl_r == 2'd1) && !tail_v_r);

  // Replacements go out first, then the tail result.
  assign out_bus.valid       = (repl_r != 2'd0) || tail_v_r;
  assign out_bus.code_point  = (repl_r != 2'd0) ? utf8d_pkg::REPLACEMENT_CP : tail_cp_r;
  assign out_bus.last_of_run = is_last;
  assign out_bus.end_of_text = (repl_r == 2'd0) && tail_end_r;

  assign stat.empty     = !out_bus.valid;
  assign stat.finishing = fire && is_last;

  // Next contents: a new request when loaded, else count down on each take.
  always_comb begin
    repl_nxt   = repl_r;
    tail_v_nxt = tail_v_r;
    if (load) begin
      repl_nxt   = desc.repl_cnt;
      tail_v_nxt = desc.tail_v;
    end else if (fire) begin
      if (repl_r != 2'd0) begin
        repl_nxt = 2'(repl_r - 2'd1);
      end else begin
        tail_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r   <= 2'd0;
      tail_v_r <= 1'b0;
    end else begin
      repl_r   <= repl_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tail_cp_r  <= desc.tail_cp;
      tail_end_r <= desc.tail_end;
    end
  end

endmodule

/* sv/utf8_byte_stream_decoder_unit.sv */
// Top level of the UTF-8 byte stream decoder: input register, decoder state,
// step logic and result register. Depends on utf8d_pkg, utf8d_if, utf8d_step, utf8d_emit.
//
//   Channel   Dir  Payload                                  Handshake
//   in_bus    in   text_byte[7:0]                           valid/ready
//   out_bus   out  code_point[20:0], last_of_run, end_of_text valid/ready
//
// A byte moves from the input register into the result register once that one is empty or
// its last result is taken, so one-result bytes stream back to back while out_bus is ready.
// A broken sequence sends up to four results from the result register, one per cycle while
// out_bus is ready, and the input side stalls until the last one is taken.
// Reset is synchronous and active low; it returns the decoder to idle.
module utf8_byte_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_bus,
  utf8d_out_if.source out_bus
);

  logic                    in_v_r, in_v_nxt;
  logic [7:0]              in_byte_r;
  logic                    move;
  utf8d_pkg::dec_state_t   state_r, state_nxt;
  utf8d_pkg::result_desc_t desc;
  utf8d_pkg::emit_stat_t   stat;

  // A byte leaves the input register once the result register can take it.
  assign move         = in_v_r && (stat.empty || stat.finishing);
  assign in_bus.ready = !in_v_r || move;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_bus.valid && in_bus.ready) begin
      in_v_nxt = 1'b1;
    end else if (move) begin
      in_v_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r <= in_bus.text_byte;
    end
  end

  utf8d_step u_step (
    .text_byte (in_byte_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .desc      (desc)
  );

  // Decoder state advances with each byte handed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (move) begin
      state_r <= state_nxt;
    end
  end

  utf8d_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (move),
    .desc    (desc),
    .stat    (stat),
    .out_bus (out_bus)
  );

`ifndef SYNTHESIS
  // The end-of-text result is always the final one for its byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.end_of_text) |-> out_bus.last_of_run)
    else $error("end_of_text on a result that is not the last of its byte");

  // An open sequence never has more bytes taken plus awaited than a four-byte form.
  a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.expect_cnt != 2'd0) |->
      ({1'b0, state_r.expect_cnt} + {1'b0, state_r.taken_cnt} <= 3'd3))
    else $error("decoder sequence counters out of range");

  // Taking a result that is not the last leaves more results pending.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && !out_bus.last_of_run) |=> out_bus.valid)
    else $error("result run ended before its last result");
`endif

endmodule
